### src/rwco_pkg.sv
// Shared types, codes and helper functions for the register write capture block.
package rwco_pkg;

  // Action codes carried by an input word.
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_ADJUST = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register index and value width limits.
  localparam logic REG_STEP_SELECT = 1'b0;
  localparam logic [4:0] VB_MIN = 5'd12;
  localparam logic [4:0] VB_MAX = 5'd16;
  localparam int KEY_W = 20;

  typedef struct packed {
    logic [1:0]        action;
    logic [4:0]        target;
    logic [31:0]       write_word;
    logic [4:0]        value_bits;
    logic              coded_hint;
    logic [8:0]        entry_select;
    logic signed [7:0] step_count;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        patched_word;
    logic [8:0]         entry_index;
    logic               new_entry;
    logic               table_full;
    logic               override_active;
    logic signed [31:0] override_amount;
    logic               status;
  } out_word_t;

  // One stored table entry.
  typedef struct packed {
    logic [4:0]       target;
    logic [KEY_W-1:0] key;
    logic [15:0]      value;
    logic             coded;
    logic             ovr_valid;
    logic [31:0]      ovr_value;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_CMP, ST_MISS, ST_HIT, ST_EDIT, ST_ADD, ST_FIN
  } state_t;

  // Edit step chosen by the step select register; codes above five saturate.
  function automatic logic [9:0] step_value(input logic [2:0] sel);
    logic [9:0] s;
    case (sel)
      3'd0:    s = 10'd1;
      3'd1:    s = 10'd16;
      3'd2:    s = 10'd256;
      3'd3:    s = 10'd10;
      3'd4:    s = 10'd100;
      default: s = 10'd1000;
    endcase
    return s;
  endfunction

  // Differential coding: each bit is the XOR of itself and the bit above.
  function automatic logic [31:0] diff_encode(input logic [31:0] v);
    logic [31:0] x;
    x = {1'b0, v[30:0]};
    return x ^ (x >> 1);
  endfunction

  // Inverse coding over the low 16 bits: a running XOR from the top down.
  function automatic logic [31:0] diff_decode(input logic [15:0] v);
    logic [15:0] r;
    r[15] = v[15];
    for (int p = 14; p >= 0; p--) begin
      r[p] = r[p+1] ^ v[p];
    end
    return {16'd0, r};
  endfunction

endpackage

### src/rwco_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rwco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/register_write_capture_override.sv
// Top level of the register write capture and override block.
//
// Input words arrive on in_valid/in_stall/in_data and each one yields exactly
// one result word on out_valid/out_stall/out_data. A snooped write scans the
// entry table one entry at a time through a single compare unit, passing
// SCAN and then CMP for each filled entry until a match; a miss appends an
// entry. Adjust words read the addressed entry directly and pass through EDIT
// and ADD, clear words through EDIT alone. Action 3 and out-of-range entry
// selects go straight to FIN.
// The block works on one word at a time: in_stall is high from acceptance
// until the result is loaded into the output register. A result held by
// out_stall waits there, and the next word may be accepted meanwhile, but it
// cannot finish until the held result is taken.
// The step select register sits at APB byte address 0. The user must write
// it only while the block is idle; the block does not enforce this. Reset
// clears the entry count, the step select and the handshake state; the table
// is not cleared and needs no clearing pass: only filled entries are searched.
module register_write_capture_override #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rwco_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rwco_pkg::out_word_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import rwco_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [2:0] step_sel_r;
  logic [1:0] act_r, act_nxt;
  logic [4:0] tgt_r, tgt_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic hint_r, hint_nxt;
  logic signed [7:0] sc_r, sc_nxt;
  logic [31:0] prod_r, prod_nxt;
  entry_t rec_r, rec_nxt;
  out_word_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;
  logic [4:0] vb_c;
  logic [31:0] ovr_enc;
  logic signed [17:0] prod_s;
  entry_t base;
  logic cfg_wr;

  rwco_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration port: one register, writes complete in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_STEP_SELECT) ? {29'd0, step_sel_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_sel_r <= 3'd0;
    end else if (cfg_wr && cfg_paddr[2] == REG_STEP_SELECT) begin
      step_sel_r <= cfg_pwdata[2:0];
    end
  end

  // Handshake outputs.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Value width clamp for the incoming word.
  always_comb begin
    if (in_data.value_bits < VB_MIN) begin
      vb_c = VB_MIN;
    end else if (in_data.value_bits > VB_MAX) begin
      vb_c = VB_MAX;
    end else begin
      vb_c = in_data.value_bits;
    end
  end

  // Override as placed into the word, coded when the entry is marked so.
  assign ovr_enc = rec_r.coded ? diff_encode(rec_r.ovr_value) : rec_r.ovr_value;

  // Step product: signed count times the unsigned step, later sign-extended.
  assign prod_s = 18'(sc_r) * 18'($signed({1'b0, step_value(step_sel_r)}));

  // Entry as read for an edit, with a fresh override seeded from its value.
  always_comb begin
    base = ram_rdata;
    if (!ram_rdata.ovr_valid) begin
      base.ovr_value = ram_rdata.coded ? diff_decode(ram_rdata.value)
                                       : {16'd0, ram_rdata.value};
    end
  end

  // Read address: the selected entry at acceptance, else the scan pointer.
  assign ram_raddr = (state_r == ST_IDLE) ? AW'(in_data.entry_select) : scan_r;

  // Sequencer: next state, datapath updates and table writes.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    scan_nxt = scan_r;
    idx_nxt = idx_r;
    act_nxt = act_r;
    tgt_nxt = tgt_r;
    word_nxt = word_r;
    mask_nxt = mask_r;
    key_nxt = key_r;
    hint_nxt = hint_r;
    sc_nxt = sc_r;
    prod_nxt = prod_r;
    rec_nxt = rec_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    ram_we = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = rec_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt = in_data.action;
          tgt_nxt = in_data.target;
          word_nxt = in_data.write_word;
          mask_nxt = (32'd1 << vb_c) - 32'd1;
          key_nxt = KEY_W'(in_data.write_word >> vb_c);
          hint_nxt = in_data.coded_hint;
          sc_nxt = in_data.step_count;
          scan_nxt = '0;
          idx_nxt = AW'(in_data.entry_select);
          res_nxt = '0;
          case (in_data.action)
            ACT_WRITE: begin
              state_nxt = (count_r == '0) ? ST_MISS : ST_SCAN;
            end
            ACT_ADJUST, ACT_CLEAR: begin
              res_nxt.entry_index = in_data.entry_select;
              state_nxt = (32'(in_data.entry_select) < TABLE_DEPTH) ? ST_EDIT : ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (ram_rdata.target == tgt_r && ram_rdata.key == key_r) begin
          idx_nxt = scan_r;
          rec_nxt = ram_rdata;
          state_nxt = ST_HIT;
        end else if (scan_r == count_r - AW'(1)) begin
          state_nxt = ST_MISS;
        end else begin
          scan_nxt = scan_r + AW'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_MISS: begin
        ram_we = 1'b1;
        ram_waddr = count_r;
        ram_wdata = '{target: tgt_r, key: key_r, value: word_r[15:0] & mask_r[15:0],
                      coded: hint_r, ovr_valid: 1'b0, ovr_value: 32'd0};
        if (count_r != LAST) begin
          count_nxt = count_r + AW'(1);
        end
        res_nxt.patched_word = word_r;
        res_nxt.entry_index = 9'(count_r);
        res_nxt.new_entry = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_HIT: begin
        ram_we = 1'b1;
        ram_wdata = rec_r;
        ram_wdata.value = word_r[15:0] & mask_r[15:0];
        res_nxt.entry_index = 9'(idx_r);
        if (rec_r.ovr_valid) begin
          res_nxt.patched_word = (word_r & ~mask_r) | (ovr_enc & mask_r);
          res_nxt.override_active = 1'b1;
          res_nxt.override_amount = rec_r.ovr_value;
        end else begin
          res_nxt.patched_word = word_r;
        end
        state_nxt = ST_FIN;
      end
      ST_EDIT: begin
        if (act_r == ACT_ADJUST) begin
          rec_nxt = base;
          rec_nxt.ovr_valid = 1'b1;
          prod_nxt = 32'(prod_s);
          state_nxt = ST_ADD;
        end else begin
          ram_wdata = ram_rdata;
          ram_wdata.ovr_valid = 1'b0;
          ram_we = ram_rdata.ovr_valid;
          res_nxt.status = !ram_rdata.ovr_valid;
          state_nxt = ST_FIN;
        end
      end
      ST_ADD: begin
        ram_we = 1'b1;
        ram_wdata = rec_r;
        ram_wdata.ovr_value = rec_r.ovr_value + prod_r;
        res_nxt.override_active = 1'b1;
        res_nxt.override_amount = rec_r.ovr_value + prod_r;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          out_data_nxt.table_full = (count_r == LAST);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    idx_r <= idx_nxt;
    act_r <= act_nxt;
    tgt_r <= tgt_nxt;
    word_r <= word_nxt;
    mask_r <= mask_nxt;
    key_r <= key_nxt;
    hint_r <= hint_nxt;
    sc_r <= sc_nxt;
    prod_r <= prod_nxt;
    rec_r <= rec_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // The entry count never passes the last slot.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST)
    else $error("entry count beyond last slot");

  // The entry count grows by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + AW'(1)))
    else $error("entry count jumped");

  // An accepted word blocks the input until its result is loaded.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while busy");

  // A new entry is only reported for a snooped write with an untouched word.
  a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MISS) |=> (res_r.new_entry && !res_r.override_active))
    else $error("new entry result malformed");

endmodule

### tb/sv/rwco_checker.sv
// Checker for the register write capture block: predicts every result word and compares it.
`timescale 1ns / 1ps

module rwco_checker #(
  parameter int DEPTH = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rwco_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rwco_pkg::out_word_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  mismatches,
  output int                  pending,
  output int                  filled_entries
);
  import rwco_pkg::*;

  // Shadow copy of the capture table and the step register.
  int          fill_count;
  logic        last_slot_used;
  logic [2:0]  step_sel;
  logic [4:0]  tbl_target [DEPTH];
  logic [31:0] tbl_key    [DEPTH];
  logic [15:0] tbl_value  [DEPTH];
  logic        tbl_coded  [DEPTH];
  logic        tbl_ovr_on [DEPTH];
  logic [31:0] tbl_ovr    [DEPTH];
  out_word_t   expected_words [$];

  // Edit step for a step select code; codes above five give the largest step.
  function automatic logic [31:0] edit_step(input logic [2:0] sel);
    case (sel)
      3'd0:    return 32'd1;
      3'd1:    return 32'd16;
      3'd2:    return 32'd256;
      3'd3:    return 32'd10;
      3'd4:    return 32'd100;
      default: return 32'd1000;
    endcase
  endfunction

  // Works out the result of one word and updates the shadow table.
  function automatic out_word_t capture_result(input in_word_t w);
    out_word_t   r;
    logic [4:0]  vb;
    logic [31:0] mask, key, ovr, acc;
    logic        hit, run;
    int          idx;
    r = '0;
    if (w.action == ACT_WRITE) begin
      vb = w.value_bits;
      if (vb < VB_MIN) vb = VB_MIN;
      if (vb > VB_MAX) vb = VB_MAX;
      mask = (32'd1 << vb) - 32'd1;
      key = w.write_word >> vb;
      hit = 1'b0;
      idx = 0;
      for (int i = 0; i < fill_count; i++) begin
        if (!hit && tbl_target[i] == w.target && tbl_key[i] == key) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (!hit) begin
        idx = fill_count;
        tbl_target[idx] = w.target;
        tbl_key[idx] = key;
        tbl_ovr_on[idx] = 1'b0;
        tbl_ovr[idx] = '0;
        tbl_coded[idx] = w.coded_hint;
        if (idx == DEPTH - 1) last_slot_used = 1'b1;
        if (fill_count + 1 < DEPTH) fill_count++;
        r.new_entry = 1'b1;
      end
      r.patched_word = w.write_word;
      if (tbl_ovr_on[idx]) begin
        ovr = tbl_ovr[idx];
        // Coded entries take the override as bit XOR the bit above it.
        if (tbl_coded[idx]) begin
          ovr[31] = 1'b0;
          ovr = ovr ^ (ovr >> 1);
        end
        r.patched_word = (w.write_word & ~mask) | (ovr & mask);
        r.override_active = 1'b1;
        r.override_amount = tbl_ovr[idx];
      end
      tbl_value[idx] = w.write_word[15:0] & mask[15:0];
      r.entry_index = idx[8:0];
    end else if (w.action == ACT_ADJUST || w.action == ACT_CLEAR) begin
      idx = w.entry_select;
      r.entry_index = w.entry_select;
      if (w.action == ACT_ADJUST) begin
        if (!tbl_ovr_on[idx]) begin
          acc = {16'd0, tbl_value[idx]};
          // Undo differential coding with a running XOR from the top bit down.
          if (tbl_coded[idx]) begin
            run = 1'b0;
            for (int p = 15; p >= 0; p--) begin
              run = run ^ tbl_value[idx][p];
              acc[p] = run;
            end
          end
          tbl_ovr[idx] = acc;
          tbl_ovr_on[idx] = 1'b1;
        end
        tbl_ovr[idx] = tbl_ovr[idx] + {{24{w.step_count[7]}}, w.step_count} * edit_step(step_sel);
      end else if (tbl_ovr_on[idx]) begin
        tbl_ovr_on[idx] = 1'b0;
      end else begin
        r.status = 1'b1;
      end
      if (tbl_ovr_on[idx]) begin
        r.override_active = 1'b1;
        r.override_amount = tbl_ovr[idx];
      end
    end
    r.table_full = (fill_count + 1 >= DEPTH);
    return r;
  endfunction

  // Predict on each accepted input word, compare each accepted result word.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      fill_count = 0;
      last_slot_used = 1'b0;
      step_sel <= '0;
      expected_words.delete();
      mismatches <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        step_sel <= cfg_pwdata[2:0];
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %p", out_data);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_data.patched_word !== exp_w.patched_word ||
              out_data.entry_index !== exp_w.entry_index ||
              out_data.new_entry !== exp_w.new_entry ||
              out_data.table_full !== exp_w.table_full ||
              out_data.override_active !== exp_w.override_active ||
              out_data.override_amount !== exp_w.override_amount ||
              out_data.status !== exp_w.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, exp_w, out_data);
          end
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(capture_result(in_data));
    end
  end

  assign pending = expected_words.size();
  assign filled_entries = fill_count + (last_slot_used ? 1 : 0);

endmodule

### tb/sv/tb.sv
// Testbench top for the register write capture block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import rwco_pkg::*;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 144;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatches;
  int          pending;
  int          filled_entries;
  logic        calm;
  int          words_sent;
  int          stall_left;

  // Recently written registers, reused to produce table hits.
  logic [4:0]  seen_target [$];
  logic [31:0] seen_word [$];
  logic [4:0]  seen_vb [$];

  register_write_capture_override u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  rwco_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .pending, .filled_entries
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

  // Gap length: mostly none or short, a few long, none in calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Result side stalls in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  // Offers one word and waits until the block takes it.
  task automatic push_word(input in_word_t w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Writes the step select register through a setup and an access cycle.
  task automatic write_step(input logic [2:0] sel);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= {$urandom_range(0, 1) ? 29'h1fffffff : 29'd0, sel};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Waits until every result has been taken, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Builds a directed word from the given field values.
  function automatic in_word_t make_word(input logic [1:0] act, input logic [4:0] tgt,
                                         input logic [31:0] wd, input logic [4:0] vb,
                                         input logic hint, input logic [8:0] sel,
                                         input logic [7:0] cnt);
    in_word_t w;
    w.action = act;
    w.target = tgt;
    w.write_word = wd;
    w.value_bits = vb;
    w.coded_hint = hint;
    w.entry_select = sel;
    w.step_count = cnt;
    return w;
  endfunction

  // Random word: mostly new or repeated writes, otherwise edits of filled entries or an occasional no-op.
  function automatic in_word_t random_word();
    in_word_t    w;
    int          r, k;
    logic [4:0]  vb;
    logic [31:0] mask;
    w = in_word_t'(($bits(in_word_t))'({$urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 3) begin
      w.action = ACT_NOP;
    end else if (r < 65 || filled_entries == 0) begin
      w.action = ACT_WRITE;
      w.value_bits = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(12, 16));
      w.target = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 17));
      if (seen_word.size() > 0 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, seen_word.size() - 1);
        vb = seen_vb[k];
        if (vb < VB_MIN) vb = VB_MIN;
        if (vb > VB_MAX) vb = VB_MAX;
        mask = (32'd1 << vb) - 32'd1;
        w.target = seen_target[k];
        w.value_bits = seen_vb[k];
        w.write_word = (seen_word[k] & ~mask) | ($urandom & mask);
      end else begin
        seen_target.push_back(w.target);
        seen_word.push_back(w.write_word);
        seen_vb.push_back(w.value_bits);
        if (seen_word.size() > 64) begin
          void'(seen_target.pop_front());
          void'(seen_word.pop_front());
          void'(seen_vb.pop_front());
        end
      end
    end else begin
      w.action = (r < 87) ? ACT_ADJUST : ACT_CLEAR;
      w.entry_select = 9'($urandom_range(0, filled_entries - 1));
    end
    return w;
  endfunction

  // Main stimulus: directed words, then random phases over the step settings.
  initial begin
    logic [2:0] phase_step [PHASES];
    phase_step = '{3'd1, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 1'b0;
    words_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_step(3'd0);

    // Directed: field extremes, clamped widths, coding, clear twice, no-op.
    push_word(make_word(ACT_WRITE, 5'd0, 32'h0000_0000, 5'd12, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_WRITE, 5'd17, 32'hffff_ffff, 5'd16, 1'b1, 9'h1ff, 8'h80));
    push_word(make_word(ACT_WRITE, 5'd16, 32'h1234_5678, 5'd3, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_WRITE, 5'd31, 32'h8765_4321, 5'd31, 1'b1, 9'd0, 8'd0));
    push_word(make_word(ACT_WRITE, 5'd0, 32'h0000_0fff, 5'd12, 1'b1, 9'd0, 8'd0));
    push_word(make_word(ACT_ADJUST, 5'd0, 32'd0, 5'd0, 1'b0, 9'd0, 8'sd127));
    push_word(make_word(ACT_ADJUST, 5'd0, 32'd0, 5'd0, 1'b0, 9'd1, 8'h80));
    push_word(make_word(ACT_WRITE, 5'd17, 32'hffff_0000, 5'd16, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_WRITE, 5'd0, 32'h0000_0abc, 5'd12, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_ADJUST, 5'd0, 32'd0, 5'd0, 1'b0, 9'd1, 8'd0));
    push_word(make_word(ACT_CLEAR, 5'd0, 32'd0, 5'd0, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_CLEAR, 5'd0, 32'd0, 5'd0, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_NOP, 5'd31, 32'hffff_ffff, 5'd31, 1'b1, 9'h1ff, 8'hff));
    push_word(make_word(ACT_ADJUST, 5'd0, 32'd0, 5'd0, 1'b0, 9'd3, 8'hff));
    push_word(make_word(ACT_WRITE, 5'd31, 32'h8765_4fff, 5'd16, 1'b0, 9'd0, 8'd0));
    push_word(make_word(ACT_CLEAR, 5'd0, 32'd0, 5'd0, 1'b0, 9'd1, 8'd0));
    push_word(make_word(ACT_WRITE, 5'd17, 32'hffff_1234, 5'd16, 1'b0, 9'd0, 8'd0));
    drain();

    // Random phases, each under its own step setting; even phases open with a calm stretch.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_step(phase_step[ph]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        calm = (n < 30) && (ph % 2 == 0);
        push_word(random_word());
      end
      calm = 1'b0;
      drain();
    end

    $display("Sent %0d words over %0d step settings; table ended with %0d entries.",
             words_sent, PHASES + 1, filled_entries);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
